FILE: hw/rtl/xmcrc_pkg.sv
// ---------------------------------------------------------------------------
// xmcrc_pkg
// Types, character codes, register indexes and helpers shared by the
// XMODEM-CRC receiver unit
// ---------------------------------------------------------------------------
`default_nettype none

package xmcrc_pkg;

	localparam int PAYLOAD_BYTES_DEF = 128;

	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;
	localparam logic [15:0] BYTE_TIMEOUT_RST = 16'd2000;
	localparam logic [3:0]  MAX_TIMEOUTS_RST = 4'd10;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 80;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUTS = 2'd2;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam logic [3:0] TIMEOUT_SAT = 4'd15;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_WAIT   = 3'd1,
		PH_DONE   = 3'd2,
		PH_CANCEL = 3'd3,
		PH_FAIL   = 3'd4,
		PH_PACKET = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_RUNNING   = 3'd1,
		ST_COMPLETE  = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_FAILED    = 3'd4
	} status_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        packet_done;
		logic        packet_good;
		status_t     session_status;
		logic [15:0] packets_total;
		logic [15:0] packets_bad;
		logic [15:0] null_starts;
		logic [3:0]  timeouts_seen;
	} result_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic status_t phase_status(input phase_t ph);
		status_t s;
		case (ph)
			PH_WAIT, PH_PACKET: s = ST_RUNNING;
			PH_DONE:            s = ST_COMPLETE;
			PH_CANCEL:          s = ST_CANCELLED;
			PH_FAIL:            s = ST_FAILED;
			default:            s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/xmodem_crc_receiver_unit.sv
// ---------------------------------------------------------------------------
// xmodem_crc_receiver_unit
// Receive end of an XMODEM-CRC download: packet framing, byte-wise CRC-16
// check, ACK/NAK/C responses, timeouts and saturating session counters
// ---------------------------------------------------------------------------
// path: a transaction passes the input register, then the result register
// throughput: one transaction per cycle unless m_tready stalls, set by the
// state update and byte-wise crc step between the input and result registers
// reset: arst_n clears the session state, counters, valid flags and config
// registers to their defaults at once
`default_nettype none

module xmodem_crc_receiver_unit #(
	parameter int PAYLOAD_BYTES = xmcrc_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [xmcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [xmcrc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	input  wire logic [7:0]                        s_tdata,  // rx_byte
	input  wire logic [1:0]                        s_tuser,  // kind
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// send_valid, send_byte, data_valid, data_byte, packet_done, packet_good,
	// session_status, packets_total, packets_bad, null_starts, timeouts_seen
	output      logic [xmcrc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import xmcrc_pkg::*;

	localparam int PKT_BYTES = PAYLOAD_BYTES + 5;
	localparam int POS_W     = $clog2(PKT_BYTES + 1);
	localparam logic [POS_W-1:0] POS_ONE      = POS_W'(1);
	localparam logic [POS_W-1:0] POS_DATA_BEG = POS_W'(3);
	localparam logic [POS_W-1:0] POS_DATA_END = POS_W'(PAYLOAD_BYTES + 3);
	localparam logic [POS_W-1:0] POS_PKT_END  = POS_W'(PKT_BYTES);

	// configuration
	logic [15:0] idle_to_q;
	logic [15:0] byte_to_q;
	logic [3:0]  max_to_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  byte_s1;

	// session state
	phase_t           phase_q, phase_n;
	logic             heard_q, heard_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [15:0]      crc_q, crc_n;
	logic [3:0]       to_cnt_q, to_cnt_n;
	logic [15:0]      tick_q, tick_n;
	logic [15:0]      total_q, total_n;
	logic [15:0]      bad_q, bad_n;
	logic [15:0]      null_q, null_n;

	// result register
	logic    out_valid_q;
	result_t res_q, res_n;

	logic advance;
	logic fire;

	logic [POS_W-1:0] pos_inc;
	logic [15:0]      tick_inc;
	logic [15:0]      tick_limit;
	logic             to_fail;
	logic [3:0]       to_cnt_inc;

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;

	assign m_tdata = {5'd0, res_q.timeouts_seen, res_q.null_starts, res_q.packets_bad,
		res_q.packets_total, res_q.session_status, res_q.packet_good, res_q.packet_done,
		res_q.data_byte, res_q.data_valid, res_q.send_byte, res_q.send_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_to_q <= IDLE_TIMEOUT_RST;
			byte_to_q <= BYTE_TIMEOUT_RST;
			max_to_q  <= MAX_TIMEOUTS_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_IDLE_TIMEOUT: idle_to_q <= cfg_data;
				REG_BYTE_TIMEOUT: byte_to_q <= cfg_data;
				REG_MAX_TIMEOUTS: max_to_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign pos_inc    = pos_q + POS_ONE;
	assign tick_inc   = sat_inc16(tick_q);
	assign tick_limit = (phase_q == PH_PACKET) ? byte_to_q : idle_to_q;
	assign to_fail    = to_cnt_q >= max_to_q;
	assign to_cnt_inc = (to_cnt_q < TIMEOUT_SAT) ? to_cnt_q + 4'd1 : to_cnt_q;

	always_comb begin
		phase_n  = phase_q;
		heard_n  = heard_q;
		pos_n    = pos_q;
		crc_n    = crc_q;
		to_cnt_n = to_cnt_q;
		tick_n   = tick_q;
		total_n  = total_q;
		bad_n    = bad_q;
		null_n   = null_q;
		res_n    = '0;

		if (kind_s1 == KIND_START) begin
			phase_n  = PH_WAIT;
			heard_n  = 1'b0;
			pos_n    = '0;
			crc_n    = '0;
			to_cnt_n = '0;
			tick_n   = '0;
			total_n  = '0;
			bad_n    = '0;
			null_n   = '0;
			res_n.send_valid = 1'b1;
			res_n.send_byte  = CH_C;
		end else if (kind_s1 == KIND_BYTE && phase_q == PH_WAIT) begin
			heard_n = 1'b1;
			tick_n  = '0;
			if (byte_s1 == CH_SOH || byte_s1 == CH_NUL) begin
				to_cnt_n = '0;
				if (byte_s1 == CH_NUL) begin
					null_n = sat_inc16(null_q);
				end
				phase_n = PH_PACKET;
				pos_n   = POS_ONE;
				crc_n   = '0;
			end else if (byte_s1 == CH_EOT) begin
				to_cnt_n = '0;
				res_n.send_valid = 1'b1;
				res_n.send_byte  = CH_ACK;
				phase_n = PH_DONE;
			end else if (byte_s1 == CH_CAN) begin
				phase_n = PH_CANCEL;
			end else begin
				to_cnt_n = to_cnt_inc;
				if (to_fail) begin
					phase_n = PH_FAIL;
				end
			end
		end else if (kind_s1 == KIND_BYTE && phase_q == PH_PACKET) begin
			tick_n   = '0;
			to_cnt_n = '0;
			if (pos_q >= POS_DATA_BEG) begin
				crc_n = crc_feed(crc_q, byte_s1);
				if (pos_q < POS_DATA_END) begin
					res_n.data_valid = 1'b1;
					res_n.data_byte  = byte_s1;
				end
			end
			if (pos_inc >= POS_PKT_END) begin
				res_n.packet_done = 1'b1;
				res_n.send_valid  = 1'b1;
				total_n = sat_inc16(total_q);
				if (crc_n == 16'd0) begin
					res_n.packet_good = 1'b1;
					res_n.send_byte   = CH_ACK;
				end else begin
					bad_n = sat_inc16(bad_q);
					res_n.send_byte = CH_NAK;
				end
				pos_n   = '0;
				crc_n   = '0;
				phase_n = PH_WAIT;
			end else begin
				pos_n = pos_inc;
			end
		end else if (kind_s1 == KIND_TICK && (phase_q == PH_WAIT || phase_q == PH_PACKET)) begin
			tick_n = tick_inc;
			if (tick_inc >= tick_limit) begin
				tick_n = '0;
				res_n.send_valid = 1'b1;
				res_n.send_byte  = (phase_q == PH_WAIT && !heard_q) ? CH_C : CH_NAK;
				pos_n    = '0;
				crc_n    = '0;
				to_cnt_n = to_cnt_inc;
				phase_n  = to_fail ? PH_FAIL : PH_WAIT;
			end
		end

		res_n.session_status = phase_status(phase_n);
		res_n.packets_total  = total_n;
		res_n.packets_bad    = bad_n;
		res_n.null_starts    = null_n;
		res_n.timeouts_seen  = to_cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			heard_q  <= 1'b0;
			pos_q    <= '0;
			crc_q    <= '0;
			to_cnt_q <= '0;
			tick_q   <= '0;
			total_q  <= '0;
			bad_q    <= '0;
			null_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			heard_q  <= heard_n;
			pos_q    <= pos_n;
			crc_q    <= crc_n;
			to_cnt_q <= to_cnt_n;
			tick_q   <= tick_n;
			total_q  <= total_n;
			bad_q    <= bad_n;
			null_q   <= null_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

	// a session once opened never returns to idle
	a_no_idle_return: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |=> (phase_q != PH_IDLE))
		else $error("session fell back to idle");

	// position and crc are cleared outside a packet
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_PACKET) |-> (pos_q == '0 && crc_q == 16'd0))
		else $error("packet state left over outside a packet");

	// a good verdict always comes with a completed packet and an ack
	a_good_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.packet_good) |->
		(res_q.packet_done && res_q.send_valid && res_q.send_byte == CH_ACK))
		else $error("good packet without ack");

	// the input side is open whenever the result register is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q) |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for xmodem_crc_receiver_unit. A short table of
// directed transactions (idle and ended sessions, lead bytes, EOT, CAN,
// restarts) is followed by randomised sessions under several timeout
// settings: mostly well-formed packets with random payload, some with CRC
// errors or cut short, mixed with tick bursts and stray bytes. Every reply
// is compared field by field to its table row or a cycle-free receiver model.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xmcrc_pkg::*;

	localparam int PAYLOAD = PAYLOAD_BYTES_DEF;
	localparam int PACKET_LEN = PAYLOAD + 5;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] b;
		bit fixed;
		result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;   // rx_byte
	logic [1:0] s_tuser;   // kind
	logic m_tvalid;
	logic m_tready = 1'b0;
	// send_valid, send_byte, data_valid, data_byte, packet_done, packet_good,
	// session_status, packets_total, packets_bad, null_starts, timeouts_seen
	logic [OUT_DATA_W-1:0] m_tdata;

	xmodem_crc_receiver_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver model state
	logic [15:0] cfg_idle_to;
	logic [15:0] cfg_byte_to;
	logic [3:0]  cfg_max_to;
	phase_t      ph;
	bit          heard;
	int          pos;
	logic [15:0] crc_acc;
	logic [3:0]  tmo_cnt;
	logic [15:0] tick_cnt;
	logic [15:0] pkt_total;
	logic [15:0] pkt_bad;
	logic [15:0] null_cnt;

	result_t pending_replies[$];
	stim_row_t directed_rows[$];
	int mismatches = 0;
	int live_items = 0;
	int items_sent = 0;
	bit calm_run = 1'b0;
	int sink_hold = 0;

	function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ 16'h1021;
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] bump16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void note_timeout();
		bit give_up;
		give_up = tmo_cnt >= cfg_max_to;
		if (tmo_cnt != TIMEOUT_SAT) begin
			tmo_cnt = tmo_cnt + 4'd1;
		end
		if (give_up) begin
			ph = PH_FAIL;
		end
	endfunction

	function automatic result_t xmodem_rx_next(logic [1:0] kind, logic [7:0] b);
		result_t r;
		bit in_pkt;
		logic [15:0] lim;
		r = '0;
		if (kind == KIND_START) begin
			ph = PH_WAIT;
			heard = 1'b0;
			pos = 0;
			crc_acc = '0;
			tmo_cnt = '0;
			tick_cnt = '0;
			pkt_total = '0;
			pkt_bad = '0;
			null_cnt = '0;
			r.send_valid = 1'b1;
			r.send_byte = CH_C;
		end else if (kind == KIND_BYTE && ph == PH_WAIT) begin
			heard = 1'b1;
			tick_cnt = '0;
			if (b == CH_SOH || b == CH_NUL) begin
				tmo_cnt = '0;
				if (b == CH_NUL) begin
					null_cnt = bump16(null_cnt);
				end
				ph = PH_PACKET;
				pos = 1;
				crc_acc = '0;
			end else if (b == CH_EOT) begin
				tmo_cnt = '0;
				r.send_valid = 1'b1;
				r.send_byte = CH_ACK;
				ph = PH_DONE;
			end else if (b == CH_CAN) begin
				ph = PH_CANCEL;
			end else begin
				note_timeout();
			end
		end else if (kind == KIND_BYTE && ph == PH_PACKET) begin
			tick_cnt = '0;
			tmo_cnt = '0;
			if (pos >= 3) begin
				crc_acc = crc16_step(crc_acc, b);
				if (pos < PAYLOAD + 3) begin
					r.data_valid = 1'b1;
					r.data_byte = b;
				end
			end
			pos++;
			if (pos >= PACKET_LEN) begin
				r.packet_done = 1'b1;
				r.send_valid = 1'b1;
				pkt_total = bump16(pkt_total);
				if (crc_acc == 16'h0000) begin
					r.packet_good = 1'b1;
					r.send_byte = CH_ACK;
				end else begin
					pkt_bad = bump16(pkt_bad);
					r.send_byte = CH_NAK;
				end
				pos = 0;
				crc_acc = '0;
				ph = PH_WAIT;
			end
		end else if (kind == KIND_TICK && (ph == PH_WAIT || ph == PH_PACKET)) begin
			in_pkt = ph == PH_PACKET;
			lim = in_pkt ? cfg_byte_to : cfg_idle_to;
			tick_cnt = bump16(tick_cnt);
			if (tick_cnt >= lim) begin
				tick_cnt = '0;
				r.send_valid = 1'b1;
				r.send_byte = (!in_pkt && !heard) ? CH_C : CH_NAK;
				pos = 0;
				crc_acc = '0;
				ph = PH_WAIT;
				note_timeout();
			end
		end
		case (ph)
			PH_WAIT, PH_PACKET: r.session_status = ST_RUNNING;
			PH_DONE:            r.session_status = ST_COMPLETE;
			PH_CANCEL:          r.session_status = ST_CANCELLED;
			PH_FAIL:            r.session_status = ST_FAILED;
			default:            r.session_status = ST_IDLE;
		endcase
		r.packets_total = pkt_total;
		r.packets_bad = pkt_bad;
		r.null_starts = null_cnt;
		r.timeouts_seen = tmo_cnt;
		return r;
	endfunction

	function automatic result_t unpack_reply(logic [OUT_DATA_W-1:0] d);
		result_t r;
		r.send_valid = d[0];
		r.send_byte = d[8:1];
		r.data_valid = d[9];
		r.data_byte = d[17:10];
		r.packet_done = d[18];
		r.packet_good = d[19];
		r.session_status = status_t'(d[22:20]);
		r.packets_total = d[38:23];
		r.packets_bad = d[54:39];
		r.null_starts = d[70:55];
		r.timeouts_seen = d[74:71];
		return r;
	endfunction

	function automatic result_t fixed_reply(logic sv, logic [7:0] sb, status_t st,
			logic [15:0] nul, logic [3:0] tmo);
		result_t r;
		r = '0;
		r.send_valid = sv;
		r.send_byte = sb;
		r.session_status = st;
		r.null_starts = nul;
		r.timeouts_seen = tmo;
		return r;
	endfunction

	function automatic void add_row(logic [1:0] kind, logic [7:0] b, bit fixed, result_t want);
		stim_row_t row;
		row.kind = kind;
		row.b = b;
		row.fixed = fixed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm_run) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 9);
		end
		return $urandom_range(10, 30);
	endfunction

	task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
		if (got !== want) begin
			flag_mismatch(what, got, want);
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = unpack_reply(m_tdata);
			if (pending_replies.size() == 0) begin
				flag_mismatch("reply with nothing pending", 16'(got.send_byte), 16'h0);
			end else begin
				want = pending_replies.pop_front();
				check_field("send_valid", 16'(got.send_valid), 16'(want.send_valid));
				check_field("send_byte", 16'(got.send_byte), 16'(want.send_byte));
				check_field("data_valid", 16'(got.data_valid), 16'(want.data_valid));
				check_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
				check_field("packet_done", 16'(got.packet_done), 16'(want.packet_done));
				check_field("packet_good", 16'(got.packet_good), 16'(want.packet_good));
				check_field("session_status", 16'(got.session_status),
					16'(want.session_status));
				check_field("packets_total", got.packets_total, want.packets_total);
				check_field("packets_bad", got.packets_bad, want.packets_bad);
				check_field("null_starts", got.null_starts, want.null_starts);
				check_field("timeouts_seen", 16'(got.timeouts_seen), 16'(want.timeouts_seen));
			end
		end
	end

	// downstream back-pressure
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			sink_hold = pick_gap();
		end
	end

	task automatic push_item(logic [1:0] kind, logic [7:0] b, bit fixed, result_t want);
		int gap;
		bit live;
		result_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		live = kind == KIND_START || ((kind == KIND_BYTE || kind == KIND_TICK) &&
			(ph == PH_WAIT || ph == PH_PACKET));
		pred = xmodem_rx_next(kind, b);
		pending_replies.push_back(fixed ? want : pred);
		if (live) begin
			live_items++;
		end
		items_sent++;
		if (items_sent % 160 == 0) begin
			calm_run = $urandom_range(0, 3) == 0;
		end
	endtask

	task automatic send(logic [1:0] kind, logic [7:0] b);
		push_item(kind, b, 1'b0, '0);
	endtask

	task automatic hold_off();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_cfg(logic [15:0] idle_to, logic [15:0] byte_to, logic [3:0] max_to);
		cfg_wen <= 1'b1;
		cfg_index <= REG_IDLE_TIMEOUT;
		cfg_data <= idle_to;
		@(posedge clk);
		cfg_index <= REG_BYTE_TIMEOUT;
		cfg_data <= byte_to;
		@(posedge clk);
		cfg_index <= REG_MAX_TIMEOUTS;
		cfg_data <= 16'(max_to);
		@(posedge clk);
		cfg_wen <= 1'b0;
		cfg_idle_to = idle_to;
		cfg_byte_to = byte_to;
		cfg_max_to = max_to;
	endtask

	task automatic tick_burst(logic [15:0] lim);
		int n;
		n = $urandom_range(1, (lim > 16'd40 ? 40 : int'(lim)) + 2);
		repeat (n) send(KIND_TICK, 8'($urandom));
	endtask

	task automatic send_packet();
		logic [7:0] frame [PACKET_LEN];
		logic [15:0] c;
		int fill;
		int cut;
		int spot;
		fill = $urandom_range(0, 19);
		frame[0] = ($urandom_range(0, 3) == 0) ? CH_NUL : CH_SOH;
		frame[1] = 8'($urandom);
		frame[2] = ~frame[1];
		c = '0;
		for (int i = 3; i < PAYLOAD + 3; i++) begin
			frame[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
			c = crc16_step(c, frame[i]);
		end
		frame[PAYLOAD + 3] = c[15:8];
		frame[PAYLOAD + 4] = c[7:0];
		if ($urandom_range(0, 3) == 0) begin
			spot = $urandom_range(3, PACKET_LEN - 1);
			frame[spot] = frame[spot] ^ 8'(1 << $urandom_range(0, 7));
		end
		cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, PACKET_LEN - 1) : PACKET_LEN;
		for (int i = 0; i < cut; i++) begin
			if (i > 0 && $urandom_range(0, 99) < 2) begin
				tick_burst(cfg_byte_to);
				if (ph != PH_PACKET) begin
					break;
				end
			end
			send(KIND_BYTE, frame[i]);
		end
		if (cut < PACKET_LEN) begin
			tick_burst(cfg_byte_to);
		end
	endtask

	task automatic run_mix(int budget);
		int target;
		int pick;
		logic [7:0] junk;
		target = live_items + budget;
		send(KIND_START, 8'($urandom));
		if ($urandom_range(0, 2) == 0) begin
			tick_burst(cfg_idle_to);
		end
		while (live_items < target) begin
			if (ph != PH_WAIT && ph != PH_PACKET) begin
				if ($urandom_range(0, 3) == 0) begin
					pick = $urandom_range(0, 2);
					send(pick == 0 ? KIND_BYTE : pick == 1 ? KIND_TICK : KIND_SPARE,
						8'($urandom));
				end
				send(KIND_START, 8'($urandom));
				if ($urandom_range(0, 2) == 0) begin
					tick_burst(cfg_idle_to);
				end
				continue;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_packet();
			end else if (pick < 80) begin
				tick_burst(ph == PH_PACKET ? cfg_byte_to : cfg_idle_to);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, int'(cfg_max_to) + 2)) begin
					junk = 8'($urandom);
					if ((junk == CH_NUL || junk == CH_SOH || junk == CH_EOT || junk == CH_CAN)
							&& $urandom_range(0, 3) != 0) begin
						junk = ~junk;
					end
					send(KIND_BYTE, junk);
				end
			end else if (pick < 92) begin
				send(KIND_BYTE, CH_EOT);
			end else if (pick < 95) begin
				send(KIND_BYTE, CH_CAN);
			end else if (pick < 98) begin
				send(KIND_START, 8'($urandom));
			end else begin
				send(KIND_SPARE, 8'($urandom));
			end
		end
	endtask

	task automatic run_phase(logic [15:0] idle_to, logic [15:0] byte_to, logic [3:0] max_to);
		hold_off();
		apply_cfg(idle_to, byte_to, max_to);
		run_mix(190);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_idle_to = IDLE_TIMEOUT_RST;
		cfg_byte_to = BYTE_TIMEOUT_RST;
		cfg_max_to = MAX_TIMEOUTS_RST;
		ph = PH_IDLE;
		heard = 1'b0;
		pos = 0;
		crc_acc = '0;
		tmo_cnt = '0;
		tick_cnt = '0;
		pkt_total = '0;
		pkt_bad = '0;
		null_cnt = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no session yet: everything ignored
		add_row(KIND_BYTE, 8'hFF, 1'b1, fixed_reply(1'b0, 8'h00, ST_IDLE, 16'd0, 4'd0));
		add_row(KIND_TICK, 8'h00, 1'b1, fixed_reply(1'b0, 8'h00, ST_IDLE, 16'd0, 4'd0));
		add_row(KIND_SPARE, 8'hAA, 1'b1, fixed_reply(1'b0, 8'h00, ST_IDLE, 16'd0, 4'd0));
		add_row(KIND_START, 8'h55, 1'b1, fixed_reply(1'b1, CH_C, ST_RUNNING, 16'd0, 4'd0));
		// stray lead bytes count as timeouts
		add_row(KIND_BYTE, 8'h02, 1'b1, fixed_reply(1'b0, 8'h00, ST_RUNNING, 16'd0, 4'd1));
		add_row(KIND_BYTE, 8'hFF, 1'b1, fixed_reply(1'b0, 8'h00, ST_RUNNING, 16'd0, 4'd2));
		add_row(KIND_BYTE, CH_EOT, 1'b1, fixed_reply(1'b1, CH_ACK, ST_COMPLETE, 16'd0, 4'd0));
		add_row(KIND_BYTE, CH_SOH, 1'b1, fixed_reply(1'b0, 8'h00, ST_COMPLETE, 16'd0, 4'd0));
		add_row(KIND_START, 8'h00, 1'b1, fixed_reply(1'b1, CH_C, ST_RUNNING, 16'd0, 4'd0));
		add_row(KIND_BYTE, CH_CAN, 1'b1, fixed_reply(1'b0, 8'h00, ST_CANCELLED, 16'd0, 4'd0));
		add_row(KIND_TICK, 8'hFF, 1'b1, fixed_reply(1'b0, 8'h00, ST_CANCELLED, 16'd0, 4'd0));
		add_row(KIND_START, 8'hFF, 1'b1, fixed_reply(1'b1, CH_C, ST_RUNNING, 16'd0, 4'd0));
		add_row(KIND_BYTE, CH_NUL, 1'b1, fixed_reply(1'b0, 8'h00, ST_RUNNING, 16'd1, 4'd0));
		// control characters inside a packet are plain data
		add_row(KIND_BYTE, CH_EOT, 1'b0, '0);
		add_row(KIND_BYTE, CH_CAN, 1'b0, '0);
		add_row(KIND_BYTE, 8'h00, 1'b0, '0);
		add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
		add_row(KIND_TICK, 8'h5A, 1'b0, '0);
		add_row(KIND_BYTE, CH_CAN, 1'b0, '0);
		// restart in the middle of a packet
		add_row(KIND_START, 8'hA5, 1'b1, fixed_reply(1'b1, CH_C, ST_RUNNING, 16'd0, 4'd0));
		add_row(KIND_BYTE, CH_SOH, 1'b0, '0);
		add_row(KIND_START, 8'h81, 1'b1, fixed_reply(1'b1, CH_C, ST_RUNNING, 16'd0, 4'd0));
		foreach (directed_rows[i]) begin
			push_item(directed_rows[i].kind, directed_rows[i].b, directed_rows[i].fixed,
				directed_rows[i].want);
		end
		run_mix(170);

		run_phase(16'd5, 16'd3, 4'd4);
		run_phase(16'd1, 16'd1, 4'd1);
		run_phase(16'd0, 16'd0, 4'd0);
		run_phase(16'hFFFF, 16'hFFFF, 4'd15);
		run_phase(16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)),
			4'($urandom_range(1, 15)));
		run_phase(16'd12, 16'd4, 4'd15);

		hold_off();
		if (pending_replies.size() != 0) begin
			flag_mismatch("replies still pending", 16'(pending_replies.size()), 16'h0);
		end
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
